// ===== rtl/core/cwfm_pkg.sv =====
`default_nettype none
package cwfm_pkg;

  // Field widths
  localparam int CAP_W      = 16;
  localparam int TICK_W     = 24;
  localparam int SCALE_W    = 16;
  localparam int OUT_W      = 34;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Saturated output value
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MPS_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MPH_SCALE = 2'd2;

  // Register reset values
  localparam logic [TICK_W-1:0]  TICK_RATE_RST = 24'd93750;
  localparam logic [SCALE_W-1:0] MPS_SCALE_RST = 16'd6423;
  localparam logic [SCALE_W-1:0] MPH_SCALE_RST = 16'd14367;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SHIFT,
    ST_DIVIDE,
    ST_SCALE_MPS,
    ST_SCALE_MPH,
    ST_DELIVER
  } cwfm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic sum_step;
    logic shift_in;
    logic div_init;
    logic div_step;
    logic scale_mps;
    logic scale_mph;
    logic load_out;
  } cwfm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hist_full;
    logic sum_last;
    logic sum_zero;
    logic div_last;
    logic out_free;
  } cwfm_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/cwfm_capture_if.sv =====
`default_nettype none
interface cwfm_capture_if;
  import cwfm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capture_count;

  modport source (output valid, output capture_count, input ready);
  modport sink   (input valid, input capture_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cwfm_result_if.sv =====
`default_nettype none
interface cwfm_result_if;
  import cwfm_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] frequency_q8;
  logic [OUT_W-1:0] speed_mps_q8;
  logic [OUT_W-1:0] speed_mph_q8;
  logic             zero_period;

  modport source (output valid, output frequency_q8, output speed_mps_q8,
                  output speed_mph_q8, output zero_period, input ready);
  modport sink   (input valid, input frequency_q8, input speed_mps_q8,
                  input speed_mph_q8, input zero_period, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cwfm_ctrl.sv =====
`default_nettype none
module cwfm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cwfm_pkg::cwfm_stat_t stat,
  output cwfm_pkg::cwfm_cmd_t       cmd
);
  import cwfm_pkg::*;

  cwfm_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = stat.hist_full ? ST_SUM : ST_SHIFT;
        end
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (stat.sum_last) state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift_in = 1'b1;
        if (!stat.hist_full) begin
          state_next = ST_IDLE;
        end else if (stat.sum_zero) begin
          state_next = ST_DELIVER;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_SCALE_MPS;
      end
      ST_SCALE_MPS: begin
        cmd.scale_mps = 1'b1;
        state_next    = ST_SCALE_MPH;
      end
      ST_SCALE_MPH: begin
        cmd.scale_mph = 1'b1;
        state_next    = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/cwfm_dpath.sv =====
`default_nettype none
module cwfm_dpath #(
  parameter int WINDOW = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [cwfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cwfm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [cwfm_pkg::CAP_W-1:0]     capture_count,
  input  wire cwfm_pkg::cwfm_cmd_t            cmd,
  output cwfm_pkg::cwfm_stat_t                stat,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [cwfm_pkg::OUT_W-1:0]          frequency_q8,
  output logic [cwfm_pkg::OUT_W-1:0]          speed_mps_q8,
  output logic [cwfm_pkg::OUT_W-1:0]          speed_mph_q8,
  output logic                                zero_period
);
  import cwfm_pkg::*;

  localparam int HIST_LEN = WINDOW - 1;
  localparam int FILL_W   = $clog2(WINDOW);
  localparam int SUM_W    = CAP_W + $clog2(WINDOW);
  localparam int MULT_W   = TICK_W + $clog2(WINDOW);
  localparam int NUM_W    = MULT_W + FRAC_W;
  localparam int CNT_W    = $clog2(NUM_W);
  localparam int QX_W     = (NUM_W > OUT_W) ? NUM_W : OUT_W;
  localparam int PROD_W   = OUT_W + SCALE_W;

  logic [TICK_W-1:0]  tick_rate;
  logic [SCALE_W-1:0] mps_scale;
  logic [SCALE_W-1:0] mph_scale;

  logic [CAP_W-1:0]  hist [HIST_LEN];
  logic [FILL_W-1:0] fill_count;
  logic [CAP_W-1:0]  cur;
  logic [CAP_W-1:0]  prev;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  step;
  logic [SUM_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [PROD_W-1:0] prod;
  logic [OUT_W-1:0]  speed_mps;

  logic [CAP_W-1:0]  diff;
  logic [MULT_W-1:0] tick_prod;
  logic [SUM_W+1:0]  trial;
  logic [QX_W-1:0]   quo_ext;
  logic [OUT_W-1:0]  freq;
  logic              hist_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= TICK_RATE_RST;
      mps_scale <= MPS_SCALE_RST;
      mph_scale <= MPH_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_RATE: tick_rate <= cfg_data[TICK_W-1:0];
        CFG_MPS_SCALE: mps_scale <= cfg_data[SCALE_W-1:0];
        CFG_MPH_SCALE: mph_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign hist_full = (fill_count == FILL_W'(HIST_LEN));

  // History: rotates once around while summing, then takes the new count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HIST_LEN; k++) hist[k] <= '0;
      fill_count <= '0;
    end else if (cmd.sum_step) begin
      for (int k = 0; k < HIST_LEN - 1; k++) hist[k] <= hist[k+1];
      hist[HIST_LEN-1] <= hist[0];
    end else if (cmd.shift_in) begin
      for (int k = 1; k < HIST_LEN; k++) hist[k] <= hist[k-1];
      hist[0] <= cur;
      if (!hist_full) fill_count <= fill_count + 1'b1;
    end
  end

  // Absolute difference of neighbors
  assign diff = (prev >= hist[0]) ? (prev - hist[0]) : (hist[0] - prev);

  // Numerator of the division: (WINDOW-1) * tick_rate, then Q.8
  assign tick_prod = MULT_W'(tick_rate) * MULT_W'(HIST_LEN);

  // Restoring division trial subtract
  assign trial = {1'b0, rem, quo[NUM_W-1]} - {2'b00, sum};

  // Saturate quotient to the output width
  assign quo_ext = QX_W'(quo);
  assign freq    = (quo_ext > QX_W'(OUT_MAX)) ? OUT_MAX : quo_ext[OUT_W-1:0];

  // Sum, divider and scaling datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur  <= capture_count;
      prev <= capture_count;
      sum  <= '0;
      step <= '0;
    end else if (cmd.sum_step) begin
      sum  <= sum + SUM_W'(diff);
      prev <= hist[0];
      step <= step + 1'b1;
    end else if (cmd.div_init) begin
      quo  <= {tick_prod, {FRAC_W{1'b0}}};
      rem  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      if (!trial[SUM_W+1]) rem <= trial[SUM_W-1:0];
      else                 rem <= {rem[SUM_W-2:0], quo[NUM_W-1]};
      quo  <= {quo[NUM_W-2:0], ~trial[SUM_W+1]};
      step <= step + 1'b1;
    end else if (cmd.scale_mps) begin
      prod <= PROD_W'(freq) * PROD_W'(mps_scale);
    end else if (cmd.scale_mph) begin
      speed_mps <= prod[PROD_W-1:SCALE_W];
      prod      <= PROD_W'(freq) * PROD_W'(mph_scale);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      zero_period <= stat.sum_zero;
      if (stat.sum_zero) begin
        frequency_q8 <= OUT_MAX;
        speed_mps_q8 <= OUT_MAX;
        speed_mph_q8 <= OUT_MAX;
      end else begin
        frequency_q8 <= freq;
        speed_mps_q8 <= speed_mps;
        speed_mph_q8 <= prod[PROD_W-1:SCALE_W];
      end
    end
  end

  // Status
  always_comb begin
    stat.hist_full = hist_full;
    stat.sum_last  = (step == CNT_W'(HIST_LEN - 1));
    stat.sum_zero  = (sum == '0);
    stat.div_last  = (step == CNT_W'(NUM_W - 1));
    stat.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ===== rtl/core/capture_window_frequency_meter.sv =====
`default_nettype none
// Channel   Dir  Beat contents
// capture   in   capture_count[15:0]
// result    out  frequency_q8[33:0], speed_mps_q8[33:0], speed_mph_q8[33:0], zero_period
// cfg       in   cfg_we, cfg_index[1:0], cfg_data[23:0] (write only)
//
// Warm-up captures (first WINDOW-1) only shift into the history and give no result.
// Later captures run through summing, history shift, the divider, mps and mph scaling and delivery;
// the restoring divider produces one quotient bit per cycle.
// A zero difference sum skips the divider and scaling.
// Synchronous reset clears history, fill count and loads default registers.
// The result sits in an output register; a new capture is taken while it waits.
module capture_window_frequency_meter #(
  parameter int WINDOW = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [cwfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cwfm_pkg::CFG_DATA_W-1:0] cfg_data,
  cwfm_capture_if.sink                        capture,
  cwfm_result_if.source                       result
);
  import cwfm_pkg::*;

  cwfm_cmd_t  cmd;
  cwfm_stat_t stat;

  cwfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (capture.valid),
    .in_ready (capture.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cwfm_dpath #(
    .WINDOW (WINDOW)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .capture_count (capture.capture_count),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .frequency_q8  (result.frequency_q8),
    .speed_mps_q8  (result.speed_mps_q8),
    .speed_mph_q8  (result.speed_mph_q8),
    .zero_period   (result.zero_period)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_capture_window_frequency_meter.sv =====
module tb_capture_window_frequency_meter;
  import cwfm_pkg::*;

  localparam int WINDOW = 5;
  localparam int HIST_N = WINDOW - 1;
  // Give the longest capture time to finish before touching registers
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AT_BEAT = 80;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 72;
  localparam longint LIMIT_TIME = 2_000_000;
  // Index with no register behind it; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] freq_q8;
    logic [OUT_W-1:0] mps_q8;
    logic [OUT_W-1:0] mph_q8;
    logic             zero_period;
  } reading_t;

  localparam reading_t SAT_READING  = '{OUT_MAX, OUT_MAX, OUT_MAX, 1'b1};
  localparam reading_t ZERO_READING = '{'0, '0, '0, 1'b0};

  typedef enum {ROW_CAPTURE, ROW_WRITE} row_kind_t;
  typedef enum {SEG_PERIODIC, SEG_STEADY, SEG_NOISE, SEG_WANDER} seg_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  value;
    bit                     typed;
    reading_t               want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cwfm_capture_if cap_ch ();
  cwfm_result_if  res_ch ();

  capture_window_frequency_meter #(.WINDOW(WINDOW)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .capture   (cap_ch.sink),
    .result    (res_ch.source)
  );

  always #5 clk = ~clk;

  // Meter model state and register copies
  logic [TICK_W-1:0]  tick_rate_cfg = TICK_RATE_RST;
  logic [SCALE_W-1:0] mps_scale_cfg = MPS_SCALE_RST;
  logic [SCALE_W-1:0] mph_scale_cfg = MPH_SCALE_RST;
  logic [CAP_W-1:0]   kept_counts[HIST_N] = '{default: '0};
  int unsigned        kept_total = 0;

  reading_t  pending_readings[$];
  step_row_t plan[$];
  int        check_errors = 0;
  bit        calm = 1'b0;

  function automatic logic [OUT_W-1:0] scale_speed(input logic [63:0] f,
                                                   input logic [SCALE_W-1:0] s);
    logic [63:0] p;
    p = (f * 64'(s)) >> 16;
    if (p > 64'(OUT_MAX)) p = 64'(OUT_MAX);
    return p[OUT_W-1:0];
  endfunction

  // Advance the capture window; returns 1 when the capture yields a reading
  function automatic bit compute_reading(input logic [CAP_W-1:0] c, output reading_t r);
    logic [CAP_W-1:0] prev;
    logic [63:0]      span;
    logic [63:0]      freq;
    bit               full;
    int               i;
    r = ZERO_READING;
    prev = c;
    span = '0;
    full = (kept_total >= HIST_N);
    if (full) begin
      for (i = 0; i < HIST_N; i++) begin
        span += (prev >= kept_counts[i]) ? 64'(prev - kept_counts[i])
                                         : 64'(kept_counts[i] - prev);
        prev = kept_counts[i];
      end
    end else begin
      kept_total++;
    end
    for (i = HIST_N - 1; i > 0; i--) kept_counts[i] = kept_counts[i-1];
    kept_counts[0] = c;
    if (!full) return 1'b0;
    if (span == 0) begin
      r = SAT_READING;
      return 1'b1;
    end
    freq = (64'(HIST_N) * 64'(tick_rate_cfg) * 64'd256) / span;
    if (freq > 64'(OUT_MAX)) freq = 64'(OUT_MAX);
    r.freq_q8 = freq[OUT_W-1:0];
    r.mps_q8 = scale_speed(freq, mps_scale_cfg);
    r.mph_q8 = scale_speed(freq, mph_scale_cfg);
    r.zero_period = 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_capture(input logic [CAP_W-1:0] c);
    plan.push_back('{ROW_CAPTURE, '0, CFG_DATA_W'(c), 1'b0, ZERO_READING});
  endfunction

  function automatic void add_typed(input logic [CAP_W-1:0] c, input reading_t want);
    plan.push_back('{ROW_CAPTURE, '0, CFG_DATA_W'(c), 1'b1, want});
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    plan.push_back('{ROW_WRITE, idx, val, 1'b0, ZERO_READING});
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return SCALE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one capture beat and hold it until taken; valid stays up for the next one
  task automatic send_capture(input logic [CAP_W-1:0] c, input bit typed,
                              input reading_t want);
    reading_t r;
    cap_ch.valid <= 1'b1;
    cap_ch.capture_count <= c;
    do @(posedge clk); while (!cap_ch.ready);
    if (compute_reading(c, r)) pending_readings.push_back(typed ? want : r);
  endtask

  task automatic pause_capture(input int n);
    cap_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 5) == 0) pause_capture($urandom_range(1, 18));
  endtask

  // Register write once the meter has drained and gone quiet
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cap_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TICK_RATE: tick_rate_cfg = val[TICK_W-1:0];
      CFG_MPS_SCALE: mps_scale_cfg = val[SCALE_W-1:0];
      CFG_MPH_SCALE: mph_scale_cfg = val[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      check_errors++;
    end
  endtask

  // Result side: check each beat, throttle ready
  initial begin : result_side
    reading_t want;
    int       gap_left;
    int       beats_seen;
    bit       long_done;
    gap_left = 0;
    beats_seen = 0;
    long_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (pending_readings.size() == 0) begin
          $display("%0t: result beat with none pending: expected nothing, actual freq %0d",
                   $time, res_ch.frequency_q8);
          check_errors++;
        end else begin
          want = pending_readings.pop_front();
          compare_field("frequency_q8", want.freq_q8, res_ch.frequency_q8);
          compare_field("speed_mps_q8", want.mps_q8, res_ch.speed_mps_q8);
          compare_field("speed_mph_q8", want.mph_q8, res_ch.speed_mph_q8);
          compare_field("zero_period", OUT_W'(want.zero_period), OUT_W'(res_ch.zero_period));
        end
        beats_seen++;
      end
      if (gap_left > 0) begin
        gap_left--;
        res_ch.ready <= 1'b0;
      end else if (!long_done && beats_seen >= HOLD_AT_BEAT) begin
        // long back-pressure so the capture side fills and stalls
        long_done = 1'b1;
        gap_left = LONG_HOLD - 1;
        res_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 18) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Capture side: directed rows, then random phases
  initial begin : capture_side
    logic [CAP_W-1:0] stamp;
    seg_kind_t        seg;
    int               ph;
    int               sent;
    int               run_len;
    int               k;
    int               period;
    int               pick;
    logic [TICK_W-1:0] tick;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cap_ch.valid <= 1'b0;
    cap_ch.capture_count <= '0;

    // Warm-up, then a flat window saturates with defaults
    add_capture(16'd0);
    add_capture(16'd0);
    add_capture(16'd0);
    add_capture(16'd0);
    add_typed(16'd0, SAT_READING);
    add_capture(16'hFFFF);
    add_capture(16'hFFFF);
    add_capture(16'd0);
    add_capture(16'hFFFF);
    // Top tick rate and full scales; later a one-tick window gives the peak frequency
    add_write(CFG_TICK_RATE, 24'hFFFFFF);
    add_write(CFG_MPS_SCALE, 24'h00FFFF);
    add_write(CFG_MPH_SCALE, 24'h00FFFF);
    add_capture(16'd1);
    add_capture(16'd0);
    add_capture(16'd1);
    add_capture(16'd0);
    add_capture(16'd1);
    add_capture(16'd7);
    add_capture(16'd7);
    add_capture(16'd7);
    add_capture(16'd7);
    add_capture(16'd8);
    add_capture(16'd8);
    // Zero tick rate zeroes the outputs; write to the spare index is dropped
    add_write(CFG_TICK_RATE, 24'd0);
    add_write(CFG_MPS_SCALE, 24'd0);
    add_write(CFG_MPH_SCALE, 24'd0);
    add_write(CFG_SPARE, 24'hFFFFFF);
    add_typed(16'd9, ZERO_READING);
    add_capture(16'd9);
    add_capture(16'd9);
    add_capture(16'd9);
    // Flat window still saturates even with no tick rate
    add_typed(16'd9, SAT_READING);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_register(plan[i].index, plan[i].value);
      end else begin
        send_capture(plan[i].value[CAP_W-1:0], plan[i].typed, plan[i].want);
        maybe_pause();
      end
    end

    stamp = CAP_W'($urandom_range(0, 65535));
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: tick = 24'd1;
        1: tick = 24'hFFFFFF;
        2: tick = TICK_RATE_RST;
        default: tick = TICK_W'($urandom_range(1, 24'hFFFFFF));
      endcase
      write_register(CFG_TICK_RATE, tick);
      write_register(CFG_MPS_SCALE, CFG_DATA_W'(pick_scale()));
      write_register(CFG_MPH_SCALE, CFG_DATA_W'(pick_scale()));
      calm = (ph == RANDOM_PHASES - 1);
      case ($urandom_range(0, 2))
        0: period = $urandom_range(1, 30);
        1: period = $urandom_range(31, 3000);
        default: period = $urandom_range(3001, 65535);
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // mostly steady pulse trains, some flat runs, noise and drift
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          seg = SEG_PERIODIC;
          run_len = $urandom_range(5, 20);
        end else if (pick < 8) begin
          seg = SEG_STEADY;
          run_len = $urandom_range(5, 7);
        end else if (pick == 8) begin
          seg = SEG_NOISE;
          run_len = $urandom_range(1, 4);
        end else begin
          seg = SEG_WANDER;
          run_len = $urandom_range(5, 10);
        end
        for (k = 0; k < run_len; k++) begin
          case (seg)
            SEG_PERIODIC: stamp = stamp + CAP_W'(period + $urandom_range(0, period / 16));
            SEG_NOISE:    stamp = CAP_W'($urandom_range(0, 65535));
            SEG_WANDER:   stamp = stamp + CAP_W'($urandom_range(0, 6)) - CAP_W'(3);
            default: ;
          endcase
          send_capture(stamp, 1'b0, ZERO_READING);
          maybe_pause();
        end
        sent += run_len;
      end
    end

    cap_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (check_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop if the meter hangs
  initial begin
    #(LIMIT_TIME);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== capture_window_frequency_meter.f =====
rtl/core/cwfm_pkg.sv
rtl/core/cwfm_capture_if.sv
rtl/core/cwfm_result_if.sv
rtl/core/cwfm_ctrl.sv
rtl/core/cwfm_dpath.sv
rtl/core/capture_window_frequency_meter.sv
tb/sv/tb_capture_window_frequency_meter.sv
